// File: sv/ctpe_pkg.sv
`default_nettype none
package ctpe_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COEF_FRAC  = 30;
    localparam int MAX_DEGREE = 10;

    localparam logic [1:0] FN_LOG  = 2'd0;
    localparam logic [1:0] FN_EXP  = 2'd1;
    localparam logic [1:0] FN_SIG  = 2'd2;
    localparam logic [1:0] FN_ZERO = 2'd3;

    localparam logic [1:0] REG_FSEL = 2'd0;
    localparam logic [1:0] REG_DEG  = 2'd1;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_cplx;

    function automatic logic signed [31:0] coef(input logic [1:0] sel, input logic [3:0] idx);
        logic signed [31:0] c;
        c = 32'sd0;
        case (sel)
            FN_LOG: begin
                case (idx)
                    4'd1:    c = 32'sd1073741824;
                    4'd2:    c = -32'sd536870912;
                    4'd3:    c = 32'sd357913941;
                    4'd4:    c = -32'sd268435456;
                    4'd5:    c = 32'sd214748365;
                    4'd6:    c = -32'sd178956971;
                    4'd7:    c = 32'sd153391689;
                    4'd8:    c = -32'sd134217728;
                    4'd9:    c = 32'sd119304647;
                    4'd10:   c = -32'sd107374182;
                    default: c = 32'sd0;
                endcase
            end
            FN_EXP: begin
                case (idx)
                    4'd0:    c = 32'sd1073741824;
                    4'd1:    c = 32'sd1073741824;
                    4'd2:    c = 32'sd536870912;
                    4'd3:    c = 32'sd178956971;
                    4'd4:    c = 32'sd44739243;
                    4'd5:    c = 32'sd8947849;
                    4'd6:    c = 32'sd1491308;
                    4'd7:    c = 32'sd213044;
                    4'd8:    c = 32'sd26631;
                    4'd9:    c = 32'sd2959;
                    4'd10:   c = 32'sd296;
                    default: c = 32'sd0;
                endcase
            end
            FN_SIG: begin
                case (idx)
                    4'd0:    c = 32'sd536870912;
                    4'd1:    c = 32'sd268435456;
                    4'd3:    c = -32'sd22369621;
                    4'd5:    c = 32'sd2236962;
                    4'd7:    c = -32'sd226359;
                    4'd9:    c = 32'sd22932;
                    default: c = 32'sd0;
                endcase
            end
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/ctpe_cmul.sv
`default_nettype none
// two-stage complex multiply, round half up, saturate
module ctpe_cmul (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  ctpe_pkg::t_cplx      i_a,
    input  ctpe_pkg::t_cplx      i_b,
    output ctpe_pkg::t_cplx      o_r,
    output logic                 o_sat
);
    logic signed [63:0] r_rr, r_ii, r_ri, r_ir;
    logic signed [65:0] s_re, s_im, q_re, q_im;
    logic               ov_re_hi, ov_re_lo, ov_im_hi, ov_im_lo;
    ctpe_pkg::t_cplx    n_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr <= i_a.re * i_b.re;
            r_ii <= i_a.im * i_b.im;
            r_ri <= i_a.re * i_b.im;
            r_ir <= i_a.im * i_b.re;
        end
    end

    always_comb begin
        s_re = 66'(r_rr) - 66'(r_ii) + (66'sd1 <<< (ctpe_pkg::FRAC_BITS - 1));
        s_im = 66'(r_ri) + 66'(r_ir) + (66'sd1 <<< (ctpe_pkg::FRAC_BITS - 1));
        q_re = s_re >>> ctpe_pkg::FRAC_BITS;
        q_im = s_im >>> ctpe_pkg::FRAC_BITS;
        ov_re_hi = q_re > 66'sd2147483647;
        ov_re_lo = q_re < -66'sd2147483648;
        ov_im_hi = q_im > 66'sd2147483647;
        ov_im_lo = q_im < -66'sd2147483648;
        n_r.re = ov_re_hi ? 32'sh7FFFFFFF : ov_re_lo ? 32'sh80000000 : q_re[31:0];
        n_r.im = ov_im_hi ? 32'sh7FFFFFFF : ov_im_lo ? 32'sh80000000 : q_im[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r   <= n_r;
            o_sat <= ov_re_hi | ov_re_lo | ov_im_hi | ov_im_lo;
        end
    end
endmodule
`default_nettype wire

// File: sv/complex_taylor_poly_eval.sv
`default_nettype none
// Throughput: one beat per cycle unless stalled; four levels of two-stage
// complex multipliers build x^2..x^10, then a coefficient multiply stage
// and two summing stages. Reset (synchronous, active low) clears the valid
// pipeline and sets function_select to 1 and poly_degree to 10.
module complex_taylor_poly_eval (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_idx,
    input  wire  [3:0]         i_cfg_data,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire signed [31:0]  i_in_real,
    input  wire signed [31:0]  i_in_imag,
    input  wire                i_in_last,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_out_real,
    output logic signed [31:0] o_out_imag,
    output logic               o_out_last,
    output logic               o_out_saturated
);
    localparam int NS = 12;

    logic [1:0]  r_fsel;
    logic [3:0]  r_deg;
    logic [3:0]  deg;
    logic        en;
    logic [NS-1:0] r_vld, r_last;

    ctpe_pkg::t_cplx r_x0;
    ctpe_pkg::t_cplx a_x2, b_x3, b_x4, c_x5, c_x6, c_x8, d_x7, d_x9, d_x10;
    logic a_f, b_f3, b_f4, c_f5, c_f6, c_f8, d_f7, d_f9, d_f10;

    ctpe_pkg::t_cplx r_da [2];
    ctpe_pkg::t_cplx r_db [2][2];
    ctpe_pkg::t_cplx r_dc [2][4];
    ctpe_pkg::t_cplx r_dd [2][7];
    logic r_fb [2];
    logic r_fc [2];
    logic r_fd [2];
    logic n_fb, n_fc, n_fd, n_fe;

    ctpe_pkg::t_cplx pw [1:10];
    logic signed [63:0] r_pre [1:10];
    logic signed [63:0] r_pim [1:10];
    logic signed [31:0] r_t0;
    logic               r_f9, r_f10;
    logic signed [39:0] n_sa_re, n_sa_im, n_sb_re, n_sb_im;
    logic signed [39:0] r_sa_re, r_sa_im, r_sb_re, r_sb_im;
    logic signed [39:0] tot_re, tot_im;
    logic signed [31:0] c0;
    logic signed [33:0] t0w;

    always_comb begin
        deg = r_deg;
        if (deg < 4'd1) deg = 4'd1;
        if (deg > 4'(ctpe_pkg::MAX_DEGREE)) deg = 4'(ctpe_pkg::MAX_DEGREE);
    end

    assign en      = !(r_vld[NS-1] && i_stall);
    assign o_stall = r_vld[NS-1] && i_stall;
    assign o_valid = r_vld[NS-1];
    assign o_out_last = r_last[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel <= 2'd1;
            r_deg  <= 4'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ctpe_pkg::REG_FSEL: r_fsel <= i_cfg_data[1:0];
                ctpe_pkg::REG_DEG:  r_deg  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last  <= {r_last[NS-2:0], i_in_last};
            r_x0.re <= i_in_real;
            r_x0.im <= i_in_imag;
        end
    end

    ctpe_cmul u_a  (.i_clk, .i_en(en), .i_a(r_x0), .i_b(r_x0), .o_r(a_x2), .o_sat(a_f));
    ctpe_cmul u_b3 (.i_clk, .i_en(en), .i_a(a_x2), .i_b(r_da[1]), .o_r(b_x3), .o_sat(b_f3));
    ctpe_cmul u_b4 (.i_clk, .i_en(en), .i_a(a_x2), .i_b(a_x2), .o_r(b_x4), .o_sat(b_f4));
    ctpe_cmul u_c5 (.i_clk, .i_en(en), .i_a(b_x4), .i_b(r_db[1][0]), .o_r(c_x5),
                    .o_sat(c_f5));
    ctpe_cmul u_c6 (.i_clk, .i_en(en), .i_a(b_x4), .i_b(r_db[1][1]), .o_r(c_x6),
                    .o_sat(c_f6));
    ctpe_cmul u_c8 (.i_clk, .i_en(en), .i_a(b_x4), .i_b(b_x4), .o_r(c_x8), .o_sat(c_f8));
    ctpe_cmul u_d7 (.i_clk, .i_en(en), .i_a(c_x6), .i_b(r_dc[1][0]), .o_r(d_x7),
                    .o_sat(d_f7));
    ctpe_cmul u_d9 (.i_clk, .i_en(en), .i_a(c_x8), .i_b(r_dc[1][0]), .o_r(d_x9),
                    .o_sat(d_f9));
    ctpe_cmul u_d10 (.i_clk, .i_en(en), .i_a(c_x8), .i_b(r_dc[1][1]), .o_r(d_x10),
                     .o_sat(d_f10));

    // flags count only for products the configured degree needs
    always_comb begin
        n_fb = a_f && (deg >= 4'd2);
        n_fc = r_fb[1] || (b_f3 && (deg >= 4'd3)) || (b_f4 && (deg >= 4'd4));
        n_fd = r_fc[1] || (c_f5 && (deg >= 4'd5)) || (c_f6 && (deg >= 4'd6))
            || (c_f8 && (deg >= 4'd8));
        n_fe = r_fd[1] || (d_f7 && (deg >= 4'd7)) || (d_f9 && (deg >= 4'd9))
            || (d_f10 && (deg >= 4'd10));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_da[0] <= r_x0;
            r_da[1] <= r_da[0];
            r_db[0][0] <= r_da[1];
            r_db[0][1] <= a_x2;
            r_db[1]    <= r_db[0];
            r_fb[0]    <= n_fb;
            r_fb[1]    <= r_fb[0];
            r_dc[0][0] <= r_db[1][0];
            r_dc[0][1] <= r_db[1][1];
            r_dc[0][2] <= b_x3;
            r_dc[0][3] <= b_x4;
            r_dc[1]    <= r_dc[0];
            r_fc[0]    <= n_fc;
            r_fc[1]    <= r_fc[0];
            r_dd[0][0] <= r_dc[1][0];
            r_dd[0][1] <= r_dc[1][1];
            r_dd[0][2] <= r_dc[1][2];
            r_dd[0][3] <= r_dc[1][3];
            r_dd[0][4] <= c_x5;
            r_dd[0][5] <= c_x6;
            r_dd[0][6] <= c_x8;
            r_dd[1]    <= r_dd[0];
            r_fd[0]    <= n_fd;
            r_fd[1]    <= r_fd[0];
        end
    end

    always_comb begin
        pw[1]  = r_dd[1][0];
        pw[2]  = r_dd[1][1];
        pw[3]  = r_dd[1][2];
        pw[4]  = r_dd[1][3];
        pw[5]  = r_dd[1][4];
        pw[6]  = r_dd[1][5];
        pw[7]  = d_x7;
        pw[8]  = r_dd[1][6];
        pw[9]  = d_x9;
        pw[10] = d_x10;
        c0  = ctpe_pkg::coef(r_fsel, 4'd0);
        t0w = (34'(c0) + (34'sd1 <<< (ctpe_pkg::COEF_FRAC - ctpe_pkg::FRAC_BITS - 1)))
            >>> (ctpe_pkg::COEF_FRAC - ctpe_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 1; i <= 10; i++) begin
                r_pre[i] <= (4'(i) <= deg) ? ctpe_pkg::coef(r_fsel, 4'(i)) * pw[i].re
                                           : 64'sd0;
                r_pim[i] <= (4'(i) <= deg) ? ctpe_pkg::coef(r_fsel, 4'(i)) * pw[i].im
                                           : 64'sd0;
            end
            r_t0  <= t0w[31:0];
            r_f9  <= n_fe;
        end
    end

    always_comb begin
        logic signed [63:0] rre, rim;
        n_sa_re = 40'(r_t0);
        n_sa_im = 40'sd0;
        n_sb_re = 40'sd0;
        n_sb_im = 40'sd0;
        for (int i = 1; i <= 10; i++) begin
            rre = (r_pre[i] + (64'sd1 <<< (ctpe_pkg::COEF_FRAC - 1))) >>> ctpe_pkg::COEF_FRAC;
            rim = (r_pim[i] + (64'sd1 <<< (ctpe_pkg::COEF_FRAC - 1))) >>> ctpe_pkg::COEF_FRAC;
            if (i <= 5) begin
                n_sa_re = n_sa_re + rre[39:0];
                n_sa_im = n_sa_im + rim[39:0];
            end else begin
                n_sb_re = n_sb_re + rre[39:0];
                n_sb_im = n_sb_im + rim[39:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa_re <= n_sa_re;
            r_sa_im <= n_sa_im;
            r_sb_re <= n_sb_re;
            r_sb_im <= n_sb_im;
            r_f10   <= r_f9;
        end
    end

    assign tot_re = r_sa_re + r_sb_re;
    assign tot_im = r_sa_im + r_sb_im;

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_real <= (tot_re > 40'sd2147483647) ? 32'sh7FFFFFFF
                        : (tot_re < -40'sd2147483648) ? 32'sh80000000 : tot_re[31:0];
            o_out_imag <= (tot_im > 40'sd2147483647) ? 32'sh7FFFFFFF
                        : (tot_im < -40'sd2147483648) ? 32'sh80000000 : tot_im[31:0];
            o_out_saturated <= r_f10 || (tot_re > 40'sd2147483647)
                || (tot_re < -40'sd2147483648) || (tot_im > 40'sd2147483647)
                || (tot_im < -40'sd2147483648);
        end
    end
endmodule
`default_nettype wire
